>>> hdl/frustum_cull_test_defines.svh
// ---------------------------------------------------------------------------
// frustum_cull_test_defines: assertion macros
// Concurrent check macros on clk with arst_n as disable.
// ---------------------------------------------------------------------------
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH
`ifndef SYNTHESIS
`define FCT_ASSERT_IMPL(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);
`define FCT_ASSERT_NEXT(name, cond, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);
`else
`define FCT_ASSERT_IMPL(name, cond, expr, msg)
`define FCT_ASSERT_NEXT(name, cond, expr, msg)
`endif
`endif

>>> hdl/fct_pkg.sv
// ---------------------------------------------------------------------------
// fct_pkg: shared definitions for the frustum cull test
// Default widths, fixed-point constants, register and verdict codes.
// ---------------------------------------------------------------------------
package fct_pkg;

	localparam int COORD_BITS_DEF = 20;
	localparam int AXIS_BITS_DEF  = 16;
	localparam int COORD_FRAC     = 8;
	localparam int TAN_BITS       = 16;
	localparam int TAN_RESET      = 256;
	localparam int CFG_IDX_BITS   = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CAMERA_POSITION = 3'd0,
		REG_FORWARD_AXIS    = 3'd1,
		REG_UP_AXIS         = 3'd2,
		REG_LEFT_AXIS       = 3'd3,
		REG_TAN_HORIZONTAL  = 3'd4,
		REG_TAN_VERTICAL    = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		VERDICT_VISIBLE = 2'd0,
		VERDICT_BEHIND  = 2'd1,
		VERDICT_OUT_H   = 2'd2,
		VERDICT_OUT_V   = 2'd3
	} verdict_t;

endpackage

>>> hdl/fct_box_if.sv
// ---------------------------------------------------------------------------
// fct_box_if: box input channel
// Valid/ready channel carrying one box center and size per transfer.
// ---------------------------------------------------------------------------
interface fct_box_if #(
	parameter int COORD_BITS = fct_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] center_x;
	logic signed [COORD_BITS-1:0] center_y;
	logic signed [COORD_BITS-1:0] center_z;
	logic        [COORD_BITS-2:0] extent_x;
	logic        [COORD_BITS-2:0] extent_y;
	logic        [COORD_BITS-2:0] extent_z;

	modport source (
		output valid, center_x, center_y, center_z, extent_x, extent_y, extent_z,
		input  ready
	);
	modport sink (
		input  valid, center_x, center_y, center_z, extent_x, extent_y, extent_z,
		output ready
	);
endinterface

>>> hdl/fct_verdict_if.sv
// ---------------------------------------------------------------------------
// fct_verdict_if: verdict output channel
// Valid/ready channel carrying one cull verdict per transfer.
// ---------------------------------------------------------------------------
interface fct_verdict_if;
	logic              valid;
	logic              ready;
	fct_pkg::verdict_t verdict;

	modport source (output valid, verdict, input ready);
	modport sink (input valid, verdict, output ready);
endinterface

>>> hdl/fct_front.sv
// ---------------------------------------------------------------------------
// fct_front: input stage
// Takes box transfers, forms the camera-relative center and the largest size.
// ---------------------------------------------------------------------------
module fct_front #(
	parameter  int COORD_BITS = fct_pkg::COORD_BITS_DEF,
	localparam int P_W        = COORD_BITS + 1,
	localparam int S_W        = COORD_BITS - 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	fct_box_if.sink                     box_in,
	input  logic [3*COORD_BITS-1:0]     camera_position,
	input  logic                        down_ready,
	output logic                        valid_s1,
	output logic signed [P_W-1:0]       p_s1 [3],
	output logic        [S_W-1:0]       s_s1 [3],
	output logic        [S_W-1:0]       smax_s1
);

	logic signed [COORD_BITS-1:0] cen [3];
	logic signed [COORD_BITS-1:0] cam [3];
	logic        [S_W-1:0]        ext [3];
	logic signed [P_W-1:0]        p_d [3];
	logic        [S_W-1:0]        smax_d;

	assign cen[0] = box_in.center_x;
	assign cen[1] = box_in.center_y;
	assign cen[2] = box_in.center_z;
	assign ext[0] = box_in.extent_x;
	assign ext[1] = box_in.extent_y;
	assign ext[2] = box_in.extent_z;

	assign box_in.ready = !valid_s1 || down_ready;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cam[i] = camera_position[i*COORD_BITS +: COORD_BITS];
			p_d[i] = P_W'(cen[i]) - P_W'(cam[i]);
		end
		smax_d = ext[0];
		if (ext[1] > smax_d) begin
			smax_d = ext[1];
		end
		if (ext[2] > smax_d) begin
			smax_d = ext[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (box_in.ready) begin
			valid_s1 <= box_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (box_in.ready) begin
			p_s1    <= p_d;
			s_s1    <= ext;
			smax_s1 <= smax_d;
		end
	end

endmodule

>>> hdl/fct_project.sv
// ---------------------------------------------------------------------------
// fct_project: axis projection stages
// Multiplies center offset and size by the forward, left and up axes, then
// sums the dot products and the absolute size spreads per axis.
// ---------------------------------------------------------------------------
module fct_project #(
	parameter  int COORD_BITS = fct_pkg::COORD_BITS_DEF,
	parameter  int AXIS_BITS  = fct_pkg::AXIS_BITS_DEF,
	localparam int P_W        = COORD_BITS + 1,
	localparam int S_W        = COORD_BITS - 1,
	localparam int PROD_W     = P_W + AXIS_BITS,
	localparam int SPROD_W    = COORD_BITS + AXIS_BITS,
	localparam int ABS_W      = COORD_BITS + AXIS_BITS - 2,
	localparam int DOT_W      = PROD_W + 2,
	localparam int SPR_W      = ABS_W + 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       up_valid,
	output logic                       up_ready,
	input  logic signed [P_W-1:0]      p [3],
	input  logic        [S_W-1:0]      s [3],
	input  logic        [S_W-1:0]      smax,
	input  logic [3*AXIS_BITS-1:0]     forward_axis,
	input  logic [3*AXIS_BITS-1:0]     left_axis,
	input  logic [3*AXIS_BITS-1:0]     up_axis,
	input  logic                       down_ready,
	output logic                       valid_s3,
	output logic signed [DOT_W-1:0]    dot_s3 [3],
	output logic        [SPR_W-1:0]    spr_s3 [3],
	output logic        [S_W-1:0]      smax_s3
);

	// axis order: forward, left, up
	logic signed [AXIS_BITS-1:0] ax [3][3];
	logic signed [PROD_W-1:0]    prod_p_s2 [3][3];
	logic signed [SPROD_W-1:0]   prod_s_s2 [3][3];
	logic        [S_W-1:0]       smax_s2;
	logic                        valid_s2;
	logic                        ready_s2;
	logic                        ready_s3;
	logic        [ABS_W-1:0]     mag [3][3];
	logic signed [DOT_W-1:0]     dot_d [3];
	logic        [SPR_W-1:0]     spr_d [3];

	assign ready_s3 = !valid_s3 || down_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign up_ready = ready_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ax[0][i] = forward_axis[i*AXIS_BITS +: AXIS_BITS];
			ax[1][i] = left_axis[i*AXIS_BITS +: AXIS_BITS];
			ax[2][i] = up_axis[i*AXIS_BITS +: AXIS_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= up_valid;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					prod_p_s2[k][i] <= p[i] * ax[k][i];
					prod_s_s2[k][i] <= $signed({1'b0, s[i]}) * ax[k][i];
				end
			end
			smax_s2 <= smax;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int i = 0; i < 3; i++) begin
				mag[k][i] = prod_s_s2[k][i][SPROD_W-1] ? ABS_W'(-prod_s_s2[k][i])
				                                      : ABS_W'(prod_s_s2[k][i]);
			end
			dot_d[k] = DOT_W'(prod_p_s2[k][0]) + DOT_W'(prod_p_s2[k][1])
			         + DOT_W'(prod_p_s2[k][2]);
			spr_d[k] = SPR_W'(mag[k][0]) + SPR_W'(mag[k][1]) + SPR_W'(mag[k][2]);
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			dot_s3  <= dot_d;
			spr_s3  <= spr_d;
			smax_s3 <= smax_s2;
		end
	end

endmodule

>>> hdl/fct_decide.sv
// ---------------------------------------------------------------------------
// fct_decide: verdict stages
// Forms the padded forward distance and side offsets, scales the distance by
// the half-angle tangents and compares, ending in the output register.
// ---------------------------------------------------------------------------
module fct_decide #(
	parameter  int COORD_BITS = fct_pkg::COORD_BITS_DEF,
	parameter  int AXIS_BITS  = fct_pkg::AXIS_BITS_DEF,
	localparam int S_W        = COORD_BITS - 1,
	localparam int DOT_W      = COORD_BITS + AXIS_BITS + 3,
	localparam int SPR_W      = COORD_BITS + AXIS_BITS,
	localparam int FWD_W      = COORD_BITS + AXIS_BITS + 4,
	localparam int LHS_W      = DOT_W + 2,
	localparam int TP_W       = FWD_W - 1 + fct_pkg::TAN_BITS,
	localparam int CMP_W      = FWD_W + fct_pkg::TAN_BITS + 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              up_valid,
	output logic                              up_ready,
	input  logic signed [DOT_W-1:0]           dot [3],
	input  logic        [SPR_W-1:0]           spr [3],
	input  logic        [S_W-1:0]             smax,
	input  logic [fct_pkg::TAN_BITS-1:0]      tan_horizontal,
	input  logic [fct_pkg::TAN_BITS-1:0]      tan_vertical,
	fct_verdict_if.source                     verdict_out
);

	logic                     valid_s4, valid_s5, valid_s6;
	logic                     ready_s4, ready_s5, ready_s6;
	logic        [DOT_W-1:0]  mag_l, mag_v;
	logic signed [FWD_W-1:0]  fwd_d, fwd_s4;
	logic signed [LHS_W-1:0]  lhs_l_d, lhs_v_d, lhs_l_s4, lhs_v_s4, lhs_l_s5, lhs_v_s5;
	logic        [S_W-1:0]    smax_s4, smax_s5;
	logic                     behind_s5;
	logic        [TP_W-1:0]   tp_h_s5, tp_v_s5;
	logic signed [CMP_W-1:0]  pad, rhs_h, rhs_v, lhs_h_ext, lhs_v_ext;
	logic                     out_h, out_v;
	fct_pkg::verdict_t        verdict_d, verdict_s6;

	assign ready_s6 = !valid_s6 || verdict_out.ready;
	assign ready_s5 = !valid_s5 || ready_s6;
	assign ready_s4 = !valid_s4 || ready_s5;
	assign up_ready = ready_s4;

	assign verdict_out.valid   = valid_s6;
	assign verdict_out.verdict = verdict_s6;

	// forward distance padded by twice the spread; side offsets doubled, less the spread
	always_comb begin
		mag_l   = dot[1][DOT_W-1] ? -dot[1] : dot[1];
		mag_v   = dot[2][DOT_W-1] ? -dot[2] : dot[2];
		fwd_d   = FWD_W'(dot[0]) + FWD_W'({spr[0], 1'b0});
		lhs_l_d = LHS_W'({1'b0, mag_l, 1'b0}) - LHS_W'(spr[1]);
		lhs_v_d = LHS_W'({1'b0, mag_v, 1'b0}) - LHS_W'(spr[2]);
	end

	// compare at the combined fraction: lhs moves up by the coordinate fraction
	always_comb begin
		pad       = CMP_W'(smax_s5) <<< (fct_pkg::COORD_FRAC + AXIS_BITS - 1);
		rhs_h     = CMP_W'({tp_h_s5, 1'b0}) + pad;
		rhs_v     = CMP_W'({tp_v_s5, 1'b0}) + pad;
		lhs_h_ext = CMP_W'(lhs_l_s5) <<< fct_pkg::COORD_FRAC;
		lhs_v_ext = CMP_W'(lhs_v_s5) <<< fct_pkg::COORD_FRAC;
		out_h     = lhs_h_ext > rhs_h;
		out_v     = lhs_v_ext > rhs_v;
		priority if (behind_s5) begin
			verdict_d = fct_pkg::VERDICT_BEHIND;
		end else if (out_h) begin
			verdict_d = fct_pkg::VERDICT_OUT_H;
		end else if (out_v) begin
			verdict_d = fct_pkg::VERDICT_OUT_V;
		end else begin
			verdict_d = fct_pkg::VERDICT_VISIBLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (ready_s4) begin
				valid_s4 <= up_valid;
			end
			if (ready_s5) begin
				valid_s5 <= valid_s4;
			end
			if (ready_s6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s4) begin
			fwd_s4   <= fwd_d;
			lhs_l_s4 <= lhs_l_d;
			lhs_v_s4 <= lhs_v_d;
			smax_s4  <= smax;
		end
		if (ready_s5) begin
			// negative distance is already decided, so the magnitude bits suffice
			behind_s5 <= fwd_s4[FWD_W-1];
			tp_h_s5   <= fwd_s4[FWD_W-2:0] * tan_horizontal;
			tp_v_s5   <= fwd_s4[FWD_W-2:0] * tan_vertical;
			lhs_l_s5  <= lhs_l_s4;
			lhs_v_s5  <= lhs_v_s4;
			smax_s5   <= smax_s4;
		end
		if (ready_s6) begin
			verdict_s6 <= verdict_d;
		end
	end

endmodule

>>> hdl/frustum_cull_test.sv
// ---------------------------------------------------------------------------
// frustum_cull_test: conservative view-frustum test for bounding boxes
// Top level: configuration registers and the six-stage cull pipeline.
// ---------------------------------------------------------------------------
// Accepts one box per clock while the input is not held, and returns one
// verdict per box, in order. The stages are: camera-relative offset, eighteen
// axis products, per-axis sums, padded distance and side offsets, tangent
// scaling, and the final compare into the output register. A stalled output
// fills bubbles first and holds the input only when all six stages are
// occupied. Camera registers must be written through cfg_we, cfg_index and
// cfg_data only while no box is in flight; the block does not enforce this.
// Indexes beyond the register list are ignored. No start-up sweep is needed.
module frustum_cull_test #(
	parameter  int COORD_BITS = fct_pkg::COORD_BITS_DEF,
	parameter  int AXIS_BITS  = fct_pkg::AXIS_BITS_DEF,
	localparam int CFG_BITS   = (3*COORD_BITS > 3*AXIS_BITS) ? 3*COORD_BITS
	                          : (3*AXIS_BITS > fct_pkg::TAN_BITS) ? 3*AXIS_BITS
	                          : fct_pkg::TAN_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	fct_box_if.sink                          box_in,
	fct_verdict_if.source                    verdict_out,
	input  logic                             cfg_we,
	input  logic [fct_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]              cfg_data
);

	`include "frustum_cull_test_defines.svh"

	localparam int P_W   = COORD_BITS + 1;
	localparam int S_W   = COORD_BITS - 1;
	localparam int DOT_W = COORD_BITS + AXIS_BITS + 3;
	localparam int SPR_W = COORD_BITS + AXIS_BITS;
	localparam int AFRAC = AXIS_BITS - 2;

	logic [3*COORD_BITS-1:0]       camera_position_q;
	logic [3*AXIS_BITS-1:0]        forward_axis_q;
	logic [3*AXIS_BITS-1:0]        up_axis_q;
	logic [3*AXIS_BITS-1:0]        left_axis_q;
	logic [fct_pkg::TAN_BITS-1:0]  tan_horizontal_q;
	logic [fct_pkg::TAN_BITS-1:0]  tan_vertical_q;

	logic                          valid_s1, ready_s1;
	logic signed [P_W-1:0]         p_s1 [3];
	logic        [S_W-1:0]         s_s1 [3];
	logic        [S_W-1:0]         smax_s1;
	logic                          valid_s3, ready_s3;
	logic signed [DOT_W-1:0]       dot_s3 [3];
	logic        [SPR_W-1:0]       spr_s3 [3];
	logic        [S_W-1:0]         smax_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_position_q <= '0;
			forward_axis_q    <= (3*AXIS_BITS)'(1) << AFRAC;
			up_axis_q         <= (3*AXIS_BITS)'(1) << (AFRAC + AXIS_BITS);
			left_axis_q       <= (3*AXIS_BITS)'(1) << (AFRAC + 2*AXIS_BITS);
			tan_horizontal_q  <= fct_pkg::TAN_BITS'(fct_pkg::TAN_RESET);
			tan_vertical_q    <= fct_pkg::TAN_BITS'(fct_pkg::TAN_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				fct_pkg::REG_CAMERA_POSITION: camera_position_q <= cfg_data[3*COORD_BITS-1:0];
				fct_pkg::REG_FORWARD_AXIS:    forward_axis_q    <= cfg_data[3*AXIS_BITS-1:0];
				fct_pkg::REG_UP_AXIS:         up_axis_q         <= cfg_data[3*AXIS_BITS-1:0];
				fct_pkg::REG_LEFT_AXIS:       left_axis_q       <= cfg_data[3*AXIS_BITS-1:0];
				fct_pkg::REG_TAN_HORIZONTAL:  tan_horizontal_q  <= cfg_data[fct_pkg::TAN_BITS-1:0];
				fct_pkg::REG_TAN_VERTICAL:    tan_vertical_q    <= cfg_data[fct_pkg::TAN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	fct_front #(
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.box_in          (box_in),
		.camera_position (camera_position_q),
		.down_ready      (ready_s1),
		.valid_s1        (valid_s1),
		.p_s1            (p_s1),
		.s_s1            (s_s1),
		.smax_s1         (smax_s1)
	);

	fct_project #(
		.COORD_BITS (COORD_BITS),
		.AXIS_BITS  (AXIS_BITS)
	) u_project (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_valid     (valid_s1),
		.up_ready     (ready_s1),
		.p            (p_s1),
		.s            (s_s1),
		.smax         (smax_s1),
		.forward_axis (forward_axis_q),
		.left_axis    (left_axis_q),
		.up_axis      (up_axis_q),
		.down_ready   (ready_s3),
		.valid_s3     (valid_s3),
		.dot_s3       (dot_s3),
		.spr_s3       (spr_s3),
		.smax_s3      (smax_s3)
	);

	fct_decide #(
		.COORD_BITS (COORD_BITS),
		.AXIS_BITS  (AXIS_BITS)
	) u_decide (
		.clk            (clk),
		.arst_n         (arst_n),
		.up_valid       (valid_s3),
		.up_ready       (ready_s3),
		.dot            (dot_s3),
		.spr            (spr_s3),
		.smax           (smax_s3),
		.tan_horizontal (tan_horizontal_q),
		.tan_vertical   (tan_vertical_q),
		.verdict_out    (verdict_out)
	);

	// input is held back only when every stage is full and the output is stalled
	`FCT_ASSERT_IMPL(a_hold_only_when_full, box_in.valid && !box_in.ready, verdict_out.valid && !verdict_out.ready, "input held while pipeline has room")
	`FCT_ASSERT_IMPL(a_ready_passes_up, verdict_out.ready, box_in.ready, "output ready did not reach the input")
	`FCT_ASSERT_NEXT(a_transfer_enters, box_in.valid && box_in.ready, valid_s1, "accepted box missing from first stage")

endmodule
